// ===== hw/rtl/rtt_pkg.sv =====
// shared types and constants of the replay token table
`default_nettype none
package rtt_pkg;

   // fixed widths of the channel fields
   localparam int TOKEN_W = 64;
   localparam int ADDR_W  = 48;
   localparam int TIME_W  = 32;
   localparam int SLOT_W  = 5;

   // sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_LAST,
      ST_DONE
   } rtt_state_type;

   // strobes from the sequencer to the datapath
   typedef struct packed {
      logic req_ready;   // request word may be taken
      logic clear_we;    // clearing pass writes an empty entry
      logic rd_en;       // scan issues a table read
      logic data_vld;    // read data is on the ram output
      logic data_first;  // read data belongs to entry zero
      logic finish;      // commit the update and load the response
   } rtt_ctl_type;

endpackage : rtt_pkg
`default_nettype wire

// ===== hw/rtl/rtt_if.sv =====
// request and response channel interfaces
`default_nettype none
interface rtt_req_if;
   import rtt_pkg::*;

   logic              valid;
   logic              ready;
   logic [TOKEN_W-1:0] token;
   logic [ADDR_W-1:0]  source_address;
   logic [TIME_W-1:0]  arrival_time;

   modport source (output valid, output token, output source_address,
                   output arrival_time, input ready);
   modport sink   (input valid, input token, input source_address,
                   input arrival_time, output ready);
endinterface : rtt_req_if

interface rtt_rsp_if;
   import rtt_pkg::*;

   logic              valid;
   logic              ready;
   logic              accepted;
   logic              inserted;
   logic [SLOT_W-1:0] slot;

   modport source (output valid, output accepted, output inserted,
                   output slot, input ready);
   modport sink   (input valid, input accepted, input inserted,
                   input slot, output ready);
endinterface : rtt_rsp_if
`default_nettype wire

// ===== hw/rtl/rtt_ram.sv =====
// generic single write port ram with registered read
`default_nettype none
module rtt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : rtt_ram
`default_nettype wire

// ===== hw/rtl/rtt_ctrl.sv =====
// sequencer: clearing pass, table scan and commit
`default_nettype none
module rtt_ctrl #(
   parameter int ENTRIES = 32
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   input  wire logic                       out_free,
   output rtt_pkg::rtt_ctl_type            ctl,
   output logic [$clog2(ENTRIES)-1:0]      idx,
   output logic [$clog2(ENTRIES)-1:0]      data_idx
);
   import rtt_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   rtt_state_type    state_ff, state_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic             data_vld_ff;
   logic [IDX_W-1:0] data_idx_ff;
   logic             cnt_last;

   assign cnt_last = (cnt_ff == LAST_IDX);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (cnt_last) state_in = ST_IDLE;
         ST_IDLE:  if (req_valid) state_in = ST_SCAN;
         ST_SCAN:  if (cnt_last) state_in = ST_LAST;
         ST_LAST:  state_in = ST_DONE;
         ST_DONE:  if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_CLEAR;
      endcase
   end

   // outputs
   always_comb begin
      ctl = '0;
      unique case (state_ff)
         ST_CLEAR: ctl.clear_we = 1'b1;
         ST_IDLE:  ctl.req_ready = 1'b1;
         ST_SCAN:  ctl.rd_en = 1'b1;
         ST_LAST:  ctl.finish = 1'b0;
         ST_DONE:  ctl.finish = out_free;
         default:  ctl = '0;
      endcase
      ctl.data_vld   = data_vld_ff;
      ctl.data_first = (data_idx_ff == '0);
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (state_ff == ST_CLEAR || state_ff == ST_SCAN) begin
         cnt_in = cnt_last ? '0 : cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         cnt_ff      <= '0;
         data_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         data_vld_ff <= (state_ff == ST_SCAN);
      end
   end

   always_ff @(posedge clock) begin
      data_idx_ff <= cnt_ff;
   end

   assign idx      = cnt_ff;
   assign data_idx = data_idx_ff;

endmodule : rtt_ctrl
`default_nettype wire

// ===== hw/rtl/rtt_scan.sv =====
// shared compare unit: token match and oldest entry tracking
`default_nettype none
module rtt_scan #(
   parameter int ENTRIES    = 32,
   parameter int TOKEN_BITS = 64
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire rtt_pkg::rtt_ctl_type         ctl,
   input  wire logic [$clog2(ENTRIES)-1:0]   data_idx,
   input  wire logic                         e_valid,
   input  wire logic [TOKEN_BITS-1:0]        e_token,
   input  wire logic [rtt_pkg::ADDR_W-1:0]   e_addr,
   input  wire logic [rtt_pkg::TIME_W-1:0]   e_time,
   input  wire logic [TOKEN_BITS-1:0]        req_token,
   output logic                              found,
   output logic [$clog2(ENTRIES)-1:0]        hit_idx,
   output logic [rtt_pkg::ADDR_W-1:0]        hit_addr,
   output logic [$clog2(ENTRIES)-1:0]        victim_idx
);
   import rtt_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);

   logic              found_ff;
   logic [IDX_W-1:0]  hit_idx_ff;
   logic [ADDR_W-1:0] hit_addr_ff;
   logic [TIME_W-1:0] best_time_ff;
   logic [IDX_W-1:0]  victim_ff;
   logic              match;
   logic              older;

   assign match = e_valid && (e_token == req_token);
   // strict compare keeps the earliest index on equal times
   assign older = (e_time < best_time_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (ctl.data_vld) begin
         if (ctl.data_first) begin
            found_ff <= match;
         end else if (match) begin
            found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.data_vld) begin
         // later matches overwrite earlier ones
         if (ctl.data_first || match) begin
            hit_idx_ff  <= data_idx;
            hit_addr_ff <= e_addr;
         end
         if (ctl.data_first || older) begin
            best_time_ff <= e_time;
            victim_ff    <= data_idx;
         end
      end
   end

   assign found      = found_ff;
   assign hit_idx    = hit_idx_ff;
   assign hit_addr   = hit_addr_ff;
   assign victim_idx = victim_ff;

endmodule : rtt_scan
`default_nettype wire

// ===== hw/rtl/replay_token_table_top.sv =====
// top level of the replay token table
//
// replay guard for connect tokens. each request word carries a token, a
// source address and an arrival time. the block walks the whole table one
// entry per cycle through a single compare unit: it remembers the last
// valid entry holding the token and the entry with the lowest stored time
// (earliest index on a tie). an unknown token overwrites that oldest entry
// and is accepted with inserted set; a known token is accepted only when
// the stored address equals the request address, and the table is left
// as is. slot carries the low 5 bits of the matched or replaced index.
// sequence: after reset the table is cleared one entry per cycle, with req
// ready low. a request is then handled in order: one table read per entry,
// a drain of the registered read, then the commit, after which the block
// is ready again. a new request word is taken only after the previous one
// has been committed, a pace set by the single read port of the table ram,
// and the commit waits while a stalled response still fills the output
// register.
// the response sits in an output register, so the next request is taken
// while the previous response still waits.
`default_nettype none
module replay_token_table_top #(
   parameter int ENTRIES    = 32,
   parameter int TOKEN_BITS = 64
) (
   input  wire logic  clock,
   input  wire logic  reset,
   rtt_req_if.sink    req_chan,
   rtt_rsp_if.source  rsp_chan
);
   import rtt_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);
   // table word: valid, token, address, time
   localparam int MEM_W = 1 + TOKEN_BITS + ADDR_W + TIME_W;

   rtt_ctl_type ctl;
   logic [IDX_W-1:0] idx;
   logic [IDX_W-1:0] data_idx;
   logic             out_free;

   // request word held for the whole scan
   logic [TOKEN_BITS-1:0] req_token_ff;
   logic [ADDR_W-1:0]     req_addr_ff;
   logic [TIME_W-1:0]     req_time_ff;

   // table ram ports
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [MEM_W-1:0] wr_data;
   logic [MEM_W-1:0] rd_data;

   // fields of the entry read back
   logic                  e_valid;
   logic [TOKEN_BITS-1:0] e_token;
   logic [ADDR_W-1:0]     e_addr;
   logic [TIME_W-1:0]     e_time;

   // scan results
   logic              found;
   logic [IDX_W-1:0]  hit_idx;
   logic [ADDR_W-1:0] hit_addr;
   logic [IDX_W-1:0]  victim_idx;

   // response register
   logic              rsp_valid_ff;
   logic              rsp_accepted_ff;
   logic              rsp_inserted_ff;
   logic [SLOT_W-1:0] rsp_slot_ff;
   logic [IDX_W-1:0]  slot_idx;
   logic [IDX_W+SLOT_W-1:0] slot_ext;

   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = ctl.req_ready;

   rtt_ctrl #(
      .ENTRIES (ENTRIES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .out_free  (out_free),
      .ctl       (ctl),
      .idx       (idx),
      .data_idx  (data_idx)
   );

   // capture the request word, only the low token bits take part
   always_ff @(posedge clock) begin
      if (req_chan.valid && ctl.req_ready) begin
         req_token_ff <= req_chan.token[TOKEN_BITS-1:0];
         req_addr_ff  <= req_chan.source_address;
         req_time_ff  <= req_chan.arrival_time;
      end
   end

   // clearing pass writes empty entries with time zero; a commit of an
   // unknown token overwrites the oldest entry
   assign wr_en   = ctl.clear_we || (ctl.finish && !found);
   assign wr_addr = ctl.clear_we ? idx : victim_idx;
   assign wr_data = ctl.clear_we ? '0
                                 : {1'b1, req_token_ff, req_addr_ff, req_time_ff};

   rtt_ram #(
      .WIDTH (MEM_W),
      .DEPTH (ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (ctl.rd_en),
      .rd_addr (idx),
      .rd_data (rd_data)
   );

   assign {e_valid, e_token, e_addr, e_time} = rd_data;

   rtt_scan #(
      .ENTRIES    (ENTRIES),
      .TOKEN_BITS (TOKEN_BITS)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .data_idx   (data_idx),
      .e_valid    (e_valid),
      .e_token    (e_token),
      .e_addr     (e_addr),
      .e_time     (e_time),
      .req_token  (req_token_ff),
      .found      (found),
      .hit_idx    (hit_idx),
      .hit_addr   (hit_addr),
      .victim_idx (victim_idx)
   );

   // slot is the index taken to 5 bits, zero extended on small tables
   assign slot_idx = found ? hit_idx : victim_idx;
   assign slot_ext = {{SLOT_W{1'b0}}, slot_idx};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.finish) begin
         rsp_accepted_ff <= !found || (hit_addr == req_addr_ff);
         rsp_inserted_ff <= !found;
         rsp_slot_ff     <= slot_ext[SLOT_W-1:0];
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.accepted = rsp_accepted_ff;
   assign rsp_chan.inserted = rsp_inserted_ff;
   assign rsp_chan.slot     = rsp_slot_ff;

endmodule : replay_token_table_top
`default_nettype wire

// ===== dv/replay_token_table_top_test.sv =====
// self-checking testbench of the replay token table top level
`default_nettype none
module replay_token_table_top_test;
   import rtt_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int ENTRIES       = 32;
   localparam int TOKEN_BITS    = 64;
   localparam int RANDOM_WORDS  = 1730;
   localparam int RECENT_DEPTH  = 40;
   localparam int HOLD_CYCLES   = 300;
   localparam int HOLD_AT       = 400;   // responses seen before the long hold-off
   localparam int DRAIN_AT      = 800;   // random word before which the sender drains
   localparam int STEADY_FIRST  = 1100;  // random words sent with no idling at all
   localparam int STEADY_LAST   = 1400;
   localparam logic [TOKEN_W-1:0] TOKEN_MASK = {TOKEN_W{1'b1}} >> (TOKEN_W - TOKEN_BITS);

   // what the block answers for one request word
   typedef struct packed {
      logic              accepted;
      logic              inserted;
      logic [SLOT_W-1:0] slot;
   } verdict_type;

   // one directed request; typed rows carry the answer written out by hand
   typedef struct packed {
      logic [TOKEN_W-1:0] token;
      logic [ADDR_W-1:0]  address;
      logic [TIME_W-1:0]  tick;
      logic               typed;
      verdict_type        verdict;
   } probe_row_type;

   localparam int DIRECTED_ROWS = 20;

   // token, address, arrival time, typed, {accepted, inserted, slot}
   probe_row_type directed_rows [DIRECTED_ROWS] = '{
      // all-zero token on an empty table is new, goes to entry zero
      '{64'h0, 48'h0, 32'h0, 1'b1, '{1'b1, 1'b1, 5'd0}},
      // same token, same address: accepted, time not refreshed
      '{64'h0, 48'h0, 32'h5, 1'b1, '{1'b1, 1'b0, 5'd0}},
      // same token from another address: rejected
      '{64'h0, 48'h1, 32'h9, 1'b1, '{1'b0, 1'b0, 5'd0}},
      // valid entry zero with time zero is taken before the empty entries
      '{64'hFFFF_FFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
        '{1'b1, 1'b1, 5'd0}},
      '{64'hFFFF_FFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'h3, 1'b1, '{1'b1, 1'b0, 5'd0}},
      '{64'hFFFF_FFFF_FFFF_FFFF, 48'h0, 32'h3, 1'b1, '{1'b0, 1'b0, 5'd0}},
      // token zero was overwritten, lowest time now sits at entry one
      '{64'h0, 48'h0, 32'h0, 1'b1, '{1'b1, 1'b1, 5'd1}},
      '{64'h0, 48'h8000_0000_0000, 32'h7, 1'b1, '{1'b0, 1'b0, 5'd1}},
      // the rest is left to the predictor
      '{64'h8000_0000_0000_0000, 48'hAAAA_AAAA_AAAA, 32'h10, 1'b0, '0},
      '{64'h5555_5555_5555_5555, 48'h5555_5555_5555, 32'h20, 1'b0, '0},
      '{64'hAAAA_AAAA_AAAA_AAAA, 48'h8000_0000_0001, 32'h8000_0000, 1'b0, '0},
      '{64'h8000_0000_0000_0000, 48'hAAAA_AAAA_AAAA, 32'h30, 1'b0, '0},
      '{64'h5555_5555_5555_5555, 48'h5555_5555_5554, 32'h31, 1'b0, '0},
      '{64'h1, 48'h1, 32'h0, 1'b0, '0},
      '{64'h2, 48'h2, 32'h40, 1'b0, '0},
      '{64'h1, 48'h1, 32'h41, 1'b0, '0},
      '{64'hFFFF_FFFF_FFFF_FFFE, 48'hFFFF_FFFF_FFFE, 32'hFFFF_FFFE, 1'b0, '0},
      '{64'h0, 48'h0, 32'h50, 1'b0, '0},
      '{64'h1234_5678_9ABC_DEF0, 48'h0123_4567_89AB, 32'h1, 1'b0, '0},
      '{64'hFFFF_FFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'h0, 1'b0, '0}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   rtt_req_if req_chan ();
   rtt_rsp_if rsp_chan ();

   replay_token_table_top #(
      .ENTRIES    (ENTRIES),
      .TOKEN_BITS (TOKEN_BITS)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #2 clock = ~clock;

   // shadow copy of the seen-token table
   logic               seen_valid   [ENTRIES];
   logic [TOKEN_W-1:0] seen_token   [ENTRIES];
   logic [ADDR_W-1:0]  seen_address [ENTRIES];
   logic [TIME_W-1:0]  seen_time    [ENTRIES];

   verdict_type pending_verdicts [$];   // answers still owed by the block, oldest first
   int          fail_count   = 0;
   int          results_seen = 0;
   bit          steady_run   = 1'b0;    // no idling on either side while set

   // look a token up in the shadow table, update it and return the answer
   function automatic verdict_type judge_token(input logic [TOKEN_W-1:0] token,
                                               input logic [ADDR_W-1:0]  address,
                                               input logic [TIME_W-1:0]  tick);
      verdict_type         answer;
      logic [TOKEN_W-1:0]  key;
      bit                  found;
      int                  hit;
      int                  oldest;
      key    = token & TOKEN_MASK;
      found  = 1'b0;
      hit    = 0;
      oldest = 0;
      // the last valid match wins, the oldest entry is the first lowest time
      for (int i = 0; i < ENTRIES; i++) begin
         if (seen_valid[i] && seen_token[i] == key) begin
            found = 1'b1;
            hit   = i;
         end
         if (seen_time[i] < seen_time[oldest])
            oldest = i;
      end
      if (!found) begin
         seen_valid[oldest]   = 1'b1;
         seen_token[oldest]   = key;
         seen_address[oldest] = address;
         seen_time[oldest]    = tick;
         answer.accepted = 1'b1;
         answer.inserted = 1'b1;
         answer.slot     = oldest[SLOT_W-1:0];
      end else begin
         answer.accepted = (seen_address[hit] == address);
         answer.inserted = 1'b0;
         answer.slot     = hit[SLOT_W-1:0];
      end
      return answer;
   endfunction

   // present one request word, maybe after an idle gap, and wait for the handshake
   task automatic offer_request(input logic [TOKEN_W-1:0] token,
                                input logic [ADDR_W-1:0]  address,
                                input logic [TIME_W-1:0]  tick,
                                input logic               typed,
                                input verdict_type        typed_verdict);
      verdict_type predicted;
      // gaps run up to a whole lookup so they land on every phase of the scan
      if (!steady_run && $urandom_range(99) < 25) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 40)) @(posedge clock);
      end
      req_chan.valid          <= 1'b1;
      req_chan.token          <= token;
      req_chan.source_address <= address;
      req_chan.arrival_time   <= tick;
      do @(posedge clock); while (!req_chan.ready);
      // word taken at this edge
      predicted = judge_token(token, address, tick);
      pending_verdicts.insert(pending_verdicts.size(), typed ? typed_verdict : predicted);
   endtask

   // drop valid and hold until every owed answer has come back
   task automatic drain_answers();
      req_chan.valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
   endtask

   // request side: directed table first, then random words
   initial begin : stimulus
      logic [TOKEN_W-1:0] token;
      logic [ADDR_W-1:0]  address;
      logic [TIME_W-1:0]  tick;
      logic [TIME_W-1:0]  now_ticks;
      logic [63:0]        wide;
      logic [TOKEN_W-1:0] recent_tokens [$];
      logic [ADDR_W-1:0]  recent_addrs  [$];
      int                 pick;
      int                 idx;

      req_chan.valid          <= 1'b0;
      req_chan.token          <= '0;
      req_chan.source_address <= '0;
      req_chan.arrival_time   <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
         seen_valid[i]   = 1'b0;
         seen_token[i]   = '0;
         seen_address[i] = '0;
         seen_time[i]    = '0;
      end
      now_ticks = 32'h100;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // the clearing pass after reset is covered by waiting on ready
      foreach (directed_rows[i])
         offer_request(directed_rows[i].token, directed_rows[i].address,
                       directed_rows[i].tick, directed_rows[i].typed,
                       directed_rows[i].verdict);
      drain_answers();

      for (int k = 0; k < RANDOM_WORDS; k++) begin
         steady_run = (k >= STEADY_FIRST && k < STEADY_LAST);
         if (k == DRAIN_AT)
            drain_answers();

         // token choice: half are repeats of recent tokens so hits and
         // rejections are frequent, plus a tiny pool with token zero and
         // fully random tokens that keep evicting old entries
         pick = $urandom_range(99);
         if (pick < 35 && recent_tokens.size() != 0) begin
            idx     = $urandom_range(recent_tokens.size() - 1);
            token   = recent_tokens[idx];
            address = recent_addrs[idx];
         end else if (pick < 50 && recent_tokens.size() != 0) begin
            idx     = $urandom_range(recent_tokens.size() - 1);
            token   = recent_tokens[idx];
            address = recent_addrs[idx] ^ (48'h1 << $urandom_range(ADDR_W - 1));
         end else if (pick < 62) begin
            token   = TOKEN_W'($urandom_range(7));
            address = ADDR_W'($urandom_range(3));
         end else begin
            token   = {$urandom, $urandom};
            wide    = {$urandom, $urandom};
            address = wide[ADDR_W-1:0];
         end

         // time mostly creeps forward, sometimes jumps or hits the extremes
         pick = $urandom_range(99);
         if (pick < 80) begin
            now_ticks = now_ticks + TIME_W'($urandom_range(24));
            tick      = now_ticks;
         end else if (pick < 90) begin
            tick = $urandom;
         end else if (pick < 95) begin
            tick = '0;
         end else begin
            tick = '1;
         end

         offer_request(token, address, tick, 1'b0, '0);

         recent_tokens.insert(recent_tokens.size(), token);
         recent_addrs.insert(recent_addrs.size(), address);
         if (recent_tokens.size() > RECENT_DEPTH) begin
            recent_tokens.delete(0);
            recent_addrs.delete(0);
         end
      end
      steady_run = 1'b0;

      // wait out the last answers, then a lookup's worth of cycles for strays
      drain_answers();
      repeat (ENTRIES + 8) @(posedge clock);

      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   // response side: random back-pressure plus one long hold-off that lets
   // the output register fill and the block stall its request side
   initial begin : response_drain
      bit held_off;
      held_off = 1'b0;
      rsp_chan.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (!held_off && results_seen >= HOLD_AT) begin
            held_off = 1'b1;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_chan.ready <= steady_run || ($urandom_range(99) >= 10);
            @(posedge clock);
         end
      end
   end

   // compare every response word with the oldest owed answer
   always @(posedge clock) begin : response_check
      verdict_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         results_seen++;
         if (pending_verdicts.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected response word: accepted %0b inserted %0b slot %0d",
                        rsp_chan.accepted, rsp_chan.inserted, rsp_chan.slot);
         end else begin
            want = pending_verdicts[0];
            pending_verdicts.delete(0);
            if (rsp_chan.accepted !== want.accepted || rsp_chan.inserted !== want.inserted ||
                rsp_chan.slot !== want.slot) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("response %0d mismatch: expected acc %0b ins %0b slot %0d, got %s",
                           results_seen, want.accepted, want.inserted, want.slot,
                           $sformatf("acc %0b ins %0b slot %0d", rsp_chan.accepted,
                                     rsp_chan.inserted, rsp_chan.slot));
            end
         end
      end
   end

   // watchdog, far beyond the slowest legal run
   initial begin : watchdog
      #4_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule : replay_token_table_top_test
`default_nettype wire
